### sv/efp_pkg.sv
// Shared types, constants and the microcode store of the escape-time fractal pixel block.
`timescale 1ns / 1ps
package efp_pkg;

  localparam int DEF_FRAME_WIDTH  = 1024;
  localparam int DEF_FRAME_HEIGHT = 1024;

  localparam int IDX_W   = 20;
  localparam int Q_W     = 32;
  localparam int Z_W     = 36;
  localparam int CNT_W   = 16;
  localparam int OFF_W   = 34;
  localparam int PROD_W  = 64;
  localparam int SQ_W    = 59;
  localparam int FRAC    = 28;
  localparam int CFGI_W  = 3;
  localparam int UC_AW   = 4;

  localparam logic [Z_W-1:0]    TWO_Q     = 36'd536870912;
  localparam logic [SQ_W:0]     FOUR_Q56  = 60'd288230376151711744;
  localparam logic [PROD_W-1:0] Q4_MAX_P  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [PROD_W-1:0] Q4_MINM_P = 64'h0000_0000_8000_0000;
  localparam logic [Q_W-1:0]    Q4_MAX    = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0]    Q4_MIN    = 32'h8000_0000;

  typedef enum logic [CFGI_W-1:0] {
    REG_MAX_ITER   = 3'd0,
    REG_ORIGIN_X   = 3'd1,
    REG_ORIGIN_Y   = 3'd2,
    REG_PIXEL_STEP = 3'd3,
    REG_JULIA_MODE = 3'd4,
    REG_JULIA_RE   = 3'd5,
    REG_JULIA_IM   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]      max_iterations;
    logic signed [Q_W-1:0] origin_x;
    logic signed [Q_W-1:0] origin_y;
    logic [Q_W-1:0]        pixel_step;
    logic                  julia_mode;
    logic signed [Q_W-1:0] julia_real;
    logic signed [Q_W-1:0] julia_imag;
  } cfg_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DIV,
    DP_OFFX,
    DP_OFFY,
    DP_MULOFF,
    DP_SATX,
    DP_SATY,
    DP_INIT,
    DP_MAG,
    DP_MSQR,
    DP_MSQI,
    DP_MCRS,
    DP_TEST,
    DP_UPD,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_IN_WAIT,
    CND_DIV_MORE,
    CND_COUNT_DONE,
    CND_BIG,
    CND_SUM_OUT,
    CND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    dp_op_t           op;
    cond_t            cond;
    logic [UC_AW-1:0] jmp;
    logic [UC_AW-1:0] nxt;
  } ctrl_t;

  typedef struct packed {
    logic in_wait;
    logic div_more;
    logic count_done;
    logic big;
    logic sum_out;
    logic out_busy;
  } status_t;

  localparam logic [UC_AW-1:0] UC_LOAD  = 4'd0;
  localparam logic [UC_AW-1:0] UC_DIV   = 4'd1;
  localparam logic [UC_AW-1:0] UC_OFFX  = 4'd2;
  localparam logic [UC_AW-1:0] UC_MULX  = 4'd3;
  localparam logic [UC_AW-1:0] UC_SATX  = 4'd4;
  localparam logic [UC_AW-1:0] UC_OFFY  = 4'd5;
  localparam logic [UC_AW-1:0] UC_MULY  = 4'd6;
  localparam logic [UC_AW-1:0] UC_SATY  = 4'd7;
  localparam logic [UC_AW-1:0] UC_INIT  = 4'd8;
  localparam logic [UC_AW-1:0] UC_MAG   = 4'd9;
  localparam logic [UC_AW-1:0] UC_MSQR  = 4'd10;
  localparam logic [UC_AW-1:0] UC_MSQI  = 4'd11;
  localparam logic [UC_AW-1:0] UC_MCRS  = 4'd12;
  localparam logic [UC_AW-1:0] UC_TEST  = 4'd13;
  localparam logic [UC_AW-1:0] UC_UPD   = 4'd14;
  localparam logic [UC_AW-1:0] UC_EMIT  = 4'd15;

  // control store: op, branch condition, taken target, fall-through target
  function automatic ctrl_t ucode(input logic [UC_AW-1:0] addr);
    ctrl_t w;
    case (addr)
      UC_LOAD: w = '{DP_LOAD,   CND_IN_WAIT,    UC_LOAD, UC_DIV};
      UC_DIV:  w = '{DP_DIV,    CND_DIV_MORE,   UC_DIV,  UC_OFFX};
      UC_OFFX: w = '{DP_OFFX,   CND_NEVER,      UC_LOAD, UC_MULX};
      UC_MULX: w = '{DP_MULOFF, CND_NEVER,      UC_LOAD, UC_SATX};
      UC_SATX: w = '{DP_SATX,   CND_NEVER,      UC_LOAD, UC_OFFY};
      UC_OFFY: w = '{DP_OFFY,   CND_NEVER,      UC_LOAD, UC_MULY};
      UC_MULY: w = '{DP_MULOFF, CND_NEVER,      UC_LOAD, UC_SATY};
      UC_SATY: w = '{DP_SATY,   CND_NEVER,      UC_LOAD, UC_INIT};
      UC_INIT: w = '{DP_INIT,   CND_NEVER,      UC_LOAD, UC_MAG};
      UC_MAG:  w = '{DP_MAG,    CND_COUNT_DONE, UC_EMIT, UC_MSQR};
      UC_MSQR: w = '{DP_MSQR,   CND_BIG,        UC_EMIT, UC_MSQI};
      UC_MSQI: w = '{DP_MSQI,   CND_NEVER,      UC_LOAD, UC_MCRS};
      UC_MCRS: w = '{DP_MCRS,   CND_NEVER,      UC_LOAD, UC_TEST};
      UC_TEST: w = '{DP_TEST,   CND_SUM_OUT,    UC_EMIT, UC_UPD};
      UC_UPD:  w = '{DP_UPD,    CND_ALWAYS,     UC_MAG,  UC_MAG};
      UC_EMIT: w = '{DP_EMIT,   CND_OUT_BUSY,   UC_EMIT, UC_LOAD};
      default: w = '{DP_NOP,    CND_ALWAYS,     UC_LOAD, UC_LOAD};
    endcase
    return w;
  endfunction

endpackage

### sv/escape_time_fractal_pixel_top.sv
// Top level of the escape-time fractal pixel block: ports, configuration registers, wiring.
`timescale 1ns / 1ps
// Usage:
//   Input stream: in_tdata carries a linear pixel index, in_tlast marks the last
//   pixel of a work chunk. One beat is taken when in_tvalid and in_tready are high.
//   Output stream: one beat per pixel with final z (Q8.28), iteration count,
//   the in-set flag on out_tuser and the chunk marker echoed on out_tlast.
//   Config: cfg_index/cfg_data written when cfg_valid is high; cfg_ready is
//   always high. Write only while no pixel is in flight.
// Sequence (one pixel at a time, a microcoded sequencer over one 32x32 multiplier):
//   load, 2 divider steps (reciprocal multiply, remainder), offset, multiply and
//   saturate for x and then for y, init, then per iteration magnitude, real square,
//   imaginary square, cross product, escape test and z update; an exit on the count
//   limit, a large component or the squared sum goes to the emit step, which loads
//   the result; the next pixel is taken as soon as the result sits in the output
//   register.
// Reset: the sequencer returns to the load step, the output register empties and
//   the configuration registers take their defaults.
// Stall: a held result keeps the output register; the next pixel computes and
//   then waits in the emit step until the register frees up.
module escape_time_fractal_pixel_top #(
  parameter int FRAME_WIDTH  = efp_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = efp_pkg::DEF_FRAME_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // [19:0] pixel_index, rest zero
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [87:0]                out_tdata,  // [35:0] final_real, [71:36] final_imag,
                                                 // [87:72] escape_count
  output logic [0:0]                 out_tuser,  // [0] in_set
  output logic                       out_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [efp_pkg::CFGI_W-1:0] cfg_index,
  input  logic [31:0]                cfg_data
);
  import efp_pkg::*;

  cfg_t    cfg_r;
  ctrl_t   ctrl;
  status_t st;

  logic [Z_W-1:0]   o_real, o_imag;
  logic [CNT_W-1:0] o_count;
  logic             o_in_set;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_iterations <= 16'd256;
      cfg_r.origin_x       <= '0;
      cfg_r.origin_y       <= '0;
      cfg_r.pixel_step     <= 32'd1342177;
      cfg_r.julia_mode     <= 1'b0;
      cfg_r.julia_real     <= '0;
      cfg_r.julia_imag     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_ITER:   cfg_r.max_iterations <= cfg_data[CNT_W-1:0];
        REG_ORIGIN_X:   cfg_r.origin_x       <= cfg_data;
        REG_ORIGIN_Y:   cfg_r.origin_y       <= cfg_data;
        REG_PIXEL_STEP: cfg_r.pixel_step     <= cfg_data;
        REG_JULIA_MODE: cfg_r.julia_mode     <= cfg_data[0];
        REG_JULIA_RE:   cfg_r.julia_real     <= cfg_data;
        REG_JULIA_IM:   cfg_r.julia_imag     <= cfg_data;
        default: ;
      endcase
    end
  end

  efp_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctrl  (ctrl)
  );

  efp_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .cfg        (cfg_r),
    .st         (st),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_index   (in_tdata[IDX_W-1:0]),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_real   (o_real),
    .out_imag   (o_imag),
    .out_count  (o_count),
    .out_in_set (o_in_set),
    .out_last   (out_tlast)
  );

  assign out_tdata = {o_count, o_imag, o_real};
  assign out_tuser = o_in_set;

endmodule

### sv/efp_sequencer.sv
// Microcode sequencer: step counter, control store lookup and branch selection.
`timescale 1ns / 1ps
module efp_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  efp_pkg::status_t st,
  output efp_pkg::ctrl_t   ctrl
);
  import efp_pkg::*;

  logic [UC_AW-1:0] pc_r, pc_nxt;
  logic             taken;

  assign ctrl = ucode(pc_r);

  always_comb begin
    case (ctrl.cond)
      CND_NEVER:      taken = 1'b0;
      CND_ALWAYS:     taken = 1'b1;
      CND_IN_WAIT:    taken = st.in_wait;
      CND_DIV_MORE:   taken = st.div_more;
      CND_COUNT_DONE: taken = st.count_done;
      CND_BIG:        taken = st.big;
      CND_SUM_OUT:    taken = st.sum_out;
      CND_OUT_BUSY:   taken = st.out_busy;
      default:        taken = 1'b0;
    endcase
    pc_nxt = taken ? ctrl.jmp : ctrl.nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UC_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### sv/efp_datapath.sv
// Datapath: index divider, point mapping, shared multiplier, z update and result register.
`timescale 1ns / 1ps
module efp_datapath #(
  parameter int FRAME_WIDTH  = efp_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = efp_pkg::DEF_FRAME_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  efp_pkg::ctrl_t                ctrl,
  input  efp_pkg::cfg_t                 cfg,
  output efp_pkg::status_t              st,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [efp_pkg::IDX_W-1:0]     in_index,
  input  logic                          in_last,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [efp_pkg::Z_W-1:0]       out_real,
  output logic [efp_pkg::Z_W-1:0]       out_imag,
  output logic [efp_pkg::CNT_W-1:0]     out_count,
  output logic                          out_in_set,
  output logic                          out_last
);
  import efp_pkg::*;

  // row = (index * RECIP) >> RSH is exact for every 20-bit index
  localparam int CW     = $clog2(FRAME_WIDTH);
  localparam int RSH    = IDX_W + CW;
  localparam int RCP_W  = IDX_W + 1;
  localparam int QP_W   = IDX_W + RCP_W;
  localparam int DCNT_W = 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RSH) + 64'(FRAME_WIDTH) - 64'd1) / 64'(FRAME_WIDTH);
  localparam logic [RCP_W-1:0]  RECIP  = RCP_W'(RECIP_L);
  localparam logic [IDX_W-1:0]  W_I    = IDX_W'(FRAME_WIDTH);
  localparam logic [OFF_W-1:0]  HALF_W = OFF_W'(FRAME_WIDTH / 2);
  localparam logic [OFF_W-1:0]  HALF_H = OFF_W'(FRAME_HEIGHT / 2);
  localparam logic [DCNT_W-1:0] DLAST  = DCNT_W'(1);

  // divider
  logic [IDX_W-1:0]  dvd_r;
  logic [IDX_W-1:0]  quo_r;
  logic [CW-1:0]     rem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [QP_W-1:0]   qprod;
  logic [IDX_W-1:0]  qw;
  logic [IDX_W-1:0]  col_full;
  logic              last_r;

  // mapping
  logic [OFF_W-1:0]  off;
  logic [Q_W-1:0]    omag_r;
  logic              oneg_r;
  logic [Q_W-1:0]    sat_v;
  logic [Q_W-1:0]    px_r, py_r;

  // multiplier
  logic [Q_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0] p_r;

  // iteration
  logic [Z_W-1:0]    zr_r, zi_r, cr_r, ci_r;
  logic [Z_W-1:0]    ar_r, ai_r;
  logic              sr_r, si_r;
  logic [SQ_W-1:0]   sqr_r, sqi_r, crs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SQ_W:0]     sq_sum;
  logic [Z_W-1:0]    tr, ti, tc, tc_s, nr, ni;

  // result register
  logic              ovalid_r;
  logic              load_out;

  assign in_tready = (ctrl.op == DP_LOAD);

  assign qprod    = {{RCP_W{1'b0}}, dvd_r} * {{IDX_W{1'b0}}, RECIP};
  assign qw       = quo_r * W_I;
  assign col_full = dvd_r - qw;

  always_comb begin
    if (ctrl.op == DP_OFFY) begin
      off = {{(OFF_W-IDX_W){1'b0}}, dvd_r} - HALF_H + {{2{cfg.origin_y[Q_W-1]}}, cfg.origin_y};
    end else begin
      off = {{(OFF_W-CW){1'b0}}, rem_r} - HALF_W
            + {{2{cfg.origin_x[Q_W-1]}}, cfg.origin_x};
    end
  end

  always_comb begin
    if (oneg_r) begin
      sat_v = (p_r > Q4_MINM_P) ? Q4_MIN : (Q_W'(0) - p_r[Q_W-1:0]);
    end else begin
      sat_v = (p_r > Q4_MAX_P) ? Q4_MAX : p_r[Q_W-1:0];
    end
  end

  always_comb begin
    case (ctrl.op)
      DP_MULOFF: begin mul_a = omag_r;         mul_b = cfg.pixel_step; end
      DP_MSQR:   begin mul_a = ar_r[Q_W-1:0];  mul_b = ar_r[Q_W-1:0];  end
      DP_MSQI:   begin mul_a = ai_r[Q_W-1:0];  mul_b = ai_r[Q_W-1:0];  end
      default:   begin mul_a = ar_r[Q_W-1:0];  mul_b = ai_r[Q_W-1:0];  end
    endcase
  end

  assign tr     = {{(Z_W-(SQ_W-FRAC)){1'b0}}, sqr_r[SQ_W-1:FRAC]};
  assign ti     = {{(Z_W-(SQ_W-FRAC)){1'b0}}, sqi_r[SQ_W-1:FRAC]};
  assign tc     = {{(Z_W-(SQ_W-FRAC)){1'b0}}, crs_r[SQ_W-1:FRAC]};
  assign tc_s   = (sr_r ^ si_r) ? (Z_W'(0) - tc) : tc;
  assign nr     = tr - ti + cr_r;
  assign ni     = {tc_s[Z_W-2:0], 1'b0} + ci_r;
  assign sq_sum = {1'b0, sqr_r} + {1'b0, sqi_r};

  assign load_out = (ctrl.op == DP_EMIT) && (!ovalid_r || out_tready);

  always_comb begin
    st.in_wait    = !in_tvalid;
    st.div_more   = (dcnt_r != DLAST);
    st.count_done = (cnt_r == cfg.max_iterations);
    st.big        = (ar_r > TWO_Q) || (ai_r > TWO_Q);
    st.sum_out    = (sq_sum > FOUR_Q56);
    st.out_busy   = ovalid_r && !out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else begin
      case (ctrl.op)
        DP_LOAD: dcnt_r <= '0;
        DP_DIV:  dcnt_r <= dcnt_r + DCNT_W'(1);
        default: dcnt_r <= dcnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_r <= {{(PROD_W-Q_W){1'b0}}, mul_a} * {{(PROD_W-Q_W){1'b0}}, mul_b};
    case (ctrl.op)
      DP_LOAD: begin
        if (in_tvalid) begin
          dvd_r  <= in_index;
          last_r <= in_last;
        end
      end
      DP_DIV: begin
        if (dcnt_r != DLAST) begin
          quo_r <= IDX_W'(qprod >> RSH);
        end else begin
          rem_r <= col_full[CW-1:0];
          dvd_r <= quo_r;
        end
      end
      DP_OFFX, DP_OFFY: begin
        oneg_r <= off[OFF_W-1];
        omag_r <= off[OFF_W-1] ? Q_W'(OFF_W'(0) - off) : off[Q_W-1:0];
      end
      DP_SATX: px_r <= sat_v;
      DP_SATY: py_r <= sat_v;
      DP_INIT: begin
        cnt_r <= '0;
        if (cfg.julia_mode) begin
          zr_r <= {{(Z_W-Q_W){px_r[Q_W-1]}}, px_r};
          zi_r <= {{(Z_W-Q_W){py_r[Q_W-1]}}, py_r};
          cr_r <= {{(Z_W-Q_W){cfg.julia_real[Q_W-1]}}, cfg.julia_real};
          ci_r <= {{(Z_W-Q_W){cfg.julia_imag[Q_W-1]}}, cfg.julia_imag};
        end else begin
          zr_r <= '0;
          zi_r <= '0;
          cr_r <= {{(Z_W-Q_W){px_r[Q_W-1]}}, px_r};
          ci_r <= {{(Z_W-Q_W){py_r[Q_W-1]}}, py_r};
        end
      end
      DP_MAG: begin
        sr_r <= zr_r[Z_W-1];
        si_r <= zi_r[Z_W-1];
        ar_r <= zr_r[Z_W-1] ? (Z_W'(0) - zr_r) : zr_r;
        ai_r <= zi_r[Z_W-1] ? (Z_W'(0) - zi_r) : zi_r;
      end
      DP_MSQI: sqr_r <= p_r[SQ_W-1:0];
      DP_MCRS: sqi_r <= p_r[SQ_W-1:0];
      DP_TEST: crs_r <= p_r[SQ_W-1:0];
      DP_UPD: begin
        zr_r  <= nr;
        zi_r  <= ni;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (load_out) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_real   <= zr_r;
      out_imag   <= zi_r;
      out_count  <= cnt_r;
      out_in_set <= (cnt_r == cfg.max_iterations);
      out_last   <= last_r;
    end
  end

  assign out_tvalid = ovalid_r;

  a_upd_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == DP_UPD) |-> (ar_r <= TWO_Q && ai_r <= TWO_Q && !st.sum_out))
    else $error("z update issued outside the escape radius");

  a_upd_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == DP_UPD) |-> (cnt_r < cfg.max_iterations))
    else $error("iteration count past the limit");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!ovalid_r || out_tready))
    else $error("result register overwritten while held");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (dcnt_r == '0 && ctrl.op == DP_DIV))
    else $error("divider not started after input beat");

endmodule
